>>> rtl/bbl_pkg.sv
// Shared types, constants and helpers for the 3x3 box blur.
// No dependencies.
package bbl_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 2048;
  localparam int unsigned MAX_HEIGHT_DEF = 2048;

  localparam int unsigned RESET_WIDTH  = 640;
  localparam int unsigned RESET_HEIGHT = 480;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned NUM_CH     = 3;
  localparam int unsigned PIX_W      = CH_W * NUM_CH;
  localparam int unsigned LINE_W     = 2 * PIX_W;
  localparam int unsigned COORD_W    = 11;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned NUM_SLOTS  = 4;

  // 9 * 255 fits in 12 bits
  localparam int unsigned SUM_W   = 12;
  localparam int unsigned CSUM3_W = 10;
  localparam int unsigned CSUM2_W = 9;

  // q = (s * recip) >> 16, exact for s <= 2295
  localparam int unsigned RECIP_W     = 15;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;

  localparam logic [RECIP_W-1:0] RECIP_9 = 15'd7282;
  localparam logic [RECIP_W-1:0] RECIP_6 = 15'd10923;
  localparam logic [RECIP_W-1:0] RECIP_4 = 15'd16384;

  typedef enum logic [1:0] {
    DIV_BY_4 = 2'd0,
    DIV_BY_6 = 2'd1,
    DIV_BY_9 = 2'd2
  } div_t;

  // results one input can release, in raster order
  typedef enum logic [1:0] {
    SLOT_UP_LEFT = 2'd0,
    SLOT_UP      = 2'd1,
    SLOT_LEFT    = 2'd2,
    SLOT_HERE    = 2'd3
  } slot_t;

  typedef struct packed {
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic row_end;
    logic last_row;
  } pos_flags_t;

  typedef struct packed {
    logic                  frame_done;
    logic                  run_last;
    logic [OUT_DATA_W-1:0] data;
  } out_item_t;

  function automatic logic [RECIP_W-1:0] recip(input div_t d);
    logic [RECIP_W-1:0] r;
    unique case (d)
      DIV_BY_9: r = RECIP_9;
      DIV_BY_6: r = RECIP_6;
      DIV_BY_4: r = RECIP_4;
      default:  r = RECIP_4;
    endcase
    return r;
  endfunction

  // clamp a dimension to [3, maxv] and return it minus one
  function automatic logic [13:0] dim_last(input logic [CFG_DATA_W-1:0] v,
                                           input int unsigned maxv);
    int unsigned d;
    d = 32'(v);
    if (d < 3) d = 3;
    if (d > maxv) d = maxv;
    return 14'(d - 1);
  endfunction

endpackage

>>> rtl/box_blur_three_by_three.sv
// 3x3 box blur over an RGB raster stream, with edge-aware divisors.
// Depends on bbl_pkg. One line memory holds the two previous rows.
//
// Channel   Direction  Payload
// in_*      input      tdata: blue[7:0] green[15:8] red[23:16]
// out_*     output     tdata: blue, green, red, row[34:24], col[45:35]; tuser: frame_done;
//                      tlast: last result of an input item
// cfg_*     input      index 0 frame_width, 1 frame_height, 12-bit data
//
// One input item per cycle while in_tready is high; the line memory is written once per
// item and read every cycle. Row ends after the first row, and last-row items after the
// first column, release two to four results; the output side moves one result per cycle
// while its skid entry is empty, so in_tready is low while such a bundle drains or the skid entry is full.
// Reset is synchronous; the line memory is not cleared and needs no sweep.
// A write to frame_width or frame_height restarts the frame at row 0, column 0.
module box_blur_three_by_three
  import bbl_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PIX_W-1:0]      in_tdata,   // blue, green, red
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // blue, green, red, row, col, 2 pad
  output logic [0:0]            out_tuser,  // frame_done
  output logic                  out_tlast,  // run_last
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // frame geometry and position
  logic [COL_W-1:0] wid_last_r;
  logic [ROW_W-1:0] hgt_last_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  pos_flags_t       pos;
  logic             accept;
  logic             cfg_wr;

  // stage 1: line memory read
  logic              p1_valid_r;
  logic [PIX_W-1:0]  p1_pix_r;
  logic [COL_W-1:0]  p1_col_r;
  logic [ROW_W-1:0]  p1_row_r;
  pos_flags_t        p1_flags_r;
  logic              p1_hold;
  logic              p1_adv;
  logic [COL_W-1:0]  rd_addr;
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] mem_q_r;

  // column sums, current column and the two before it
  logic [CSUM3_W-1:0] s3_cur  [NUM_CH];
  logic [CSUM2_W-1:0] s2_cur  [NUM_CH];
  logic [CSUM3_W-1:0] s3_m1_r [NUM_CH];
  logic [CSUM3_W-1:0] s3_m2_r [NUM_CH];
  logic [CSUM2_W-1:0] s2_m1_r [NUM_CH];
  logic [CSUM2_W-1:0] s2_m2_r [NUM_CH];

  logic [SUM_W-1:0]     sum_nxt  [NUM_SLOTS][NUM_CH];
  div_t                 div_nxt  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] mask_nxt;

  // stage 2: bundle of released results
  logic [NUM_SLOTS-1:0] b_mask_r;
  logic [SUM_W-1:0]     b_sum_r [NUM_SLOTS][NUM_CH];
  div_t                 b_div_r [NUM_SLOTS];
  logic [COL_W-1:0]     b_col_r;
  logic [ROW_W-1:0]     b_row_r;
  logic                 b_valid;
  logic                 b_single;
  logic                 b_take;
  logic                 b_emit;
  slot_t                sel_slot;
  logic [ROW_W-1:0]     sel_row;
  logic [COL_W-1:0]     sel_col;
  logic [PROD_W-1:0]    prod [NUM_CH];
  logic [CH_W-1:0]      quot [NUM_CH];
  out_item_t            res_nxt;

  // output register with skid entry
  logic      oh_valid_r;
  logic      os_valid_r;
  out_item_t oh_item_r;
  out_item_t os_item_r;
  logic      out_pop;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    pos.r_ge1    = (row_r != '0);
    pos.r_ge2    = (row_r > ROW_W'(1));
    pos.c_ge1    = (col_r != '0);
    pos.c_ge2    = (col_r > COL_W'(1));
    pos.row_end  = (col_r == wid_last_r);
    pos.last_row = (row_r == hgt_last_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wid_last_r <= COL_W'(dim_last(CFG_DATA_W'(RESET_WIDTH), MAX_WIDTH));
      hgt_last_r <= ROW_W'(dim_last(CFG_DATA_W'(RESET_HEIGHT), MAX_HEIGHT));
      col_r      <= '0;
      row_r      <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH: begin
          wid_last_r <= COL_W'(dim_last(cfg_data, MAX_WIDTH));
          col_r      <= '0;
          row_r      <= '0;
        end
        CFG_FRAME_HEIGHT: begin
          hgt_last_r <= ROW_W'(dim_last(cfg_data, MAX_HEIGHT));
          col_r      <= '0;
          row_r      <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (pos.row_end) begin
        col_r <= '0;
        row_r <= pos.last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
  end

  // stage 1 control
  assign p1_hold   = p1_valid_r && !b_take;
  assign p1_adv    = p1_valid_r && b_take;
  assign in_tready = !p1_hold;
  assign rd_addr   = p1_hold ? p1_col_r : col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (accept) begin
      p1_valid_r <= 1'b1;
    end else if (p1_adv) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_pix_r   <= in_tdata;
      p1_col_r   <= col_r;
      p1_row_r   <= row_r;
      p1_flags_r <= pos;
    end
  end

  // word layout: [47:24] row above, [23:0] two rows above
  always_ff @(posedge clk) begin
    if (p1_adv) begin
      line_mem[p1_col_r] <= {p1_pix_r, mem_q_r[LINE_W-1:PIX_W]};
    end
    mem_q_r <= line_mem[rd_addr];
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      s2_cur[ch] = CSUM2_W'(mem_q_r[PIX_W + ch*CH_W +: CH_W])
                 + CSUM2_W'(p1_pix_r[ch*CH_W +: CH_W]);
      s3_cur[ch] = CSUM3_W'(s2_cur[ch])
                 + (p1_flags_r.r_ge2 ? CSUM3_W'(mem_q_r[ch*CH_W +: CH_W]) : '0);

      sum_nxt[SLOT_UP_LEFT][ch] = SUM_W'(s3_cur[ch]) + SUM_W'(s3_m1_r[ch])
                                + (p1_flags_r.c_ge2 ? SUM_W'(s3_m2_r[ch]) : '0);
      sum_nxt[SLOT_UP][ch]      = SUM_W'(s3_cur[ch]) + SUM_W'(s3_m1_r[ch]);
      sum_nxt[SLOT_LEFT][ch]    = SUM_W'(s2_cur[ch]) + SUM_W'(s2_m1_r[ch])
                                + (p1_flags_r.c_ge2 ? SUM_W'(s2_m2_r[ch]) : '0);
      sum_nxt[SLOT_HERE][ch]    = SUM_W'(s2_cur[ch]) + SUM_W'(s2_m1_r[ch]);
    end

    if (p1_flags_r.r_ge2 && p1_flags_r.c_ge2) begin
      div_nxt[SLOT_UP_LEFT] = DIV_BY_9;
    end else if (p1_flags_r.r_ge2 || p1_flags_r.c_ge2) begin
      div_nxt[SLOT_UP_LEFT] = DIV_BY_6;
    end else begin
      div_nxt[SLOT_UP_LEFT] = DIV_BY_4;
    end
    div_nxt[SLOT_UP]   = p1_flags_r.r_ge2 ? DIV_BY_6 : DIV_BY_4;
    div_nxt[SLOT_LEFT] = p1_flags_r.c_ge2 ? DIV_BY_6 : DIV_BY_4;
    div_nxt[SLOT_HERE] = DIV_BY_4;

    mask_nxt[SLOT_UP_LEFT] = p1_flags_r.r_ge1 && p1_flags_r.c_ge1;
    mask_nxt[SLOT_UP]      = p1_flags_r.r_ge1 && p1_flags_r.row_end;
    mask_nxt[SLOT_LEFT]    = p1_flags_r.last_row && p1_flags_r.c_ge1;
    mask_nxt[SLOT_HERE]    = p1_flags_r.last_row && p1_flags_r.row_end;
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s3_m2_r[ch] <= s3_m1_r[ch];
        s3_m1_r[ch] <= s3_cur[ch];
        s2_m2_r[ch] <= s2_m1_r[ch];
        s2_m1_r[ch] <= s2_cur[ch];
      end
      b_sum_r <= sum_nxt;
      b_div_r <= div_nxt;
      b_col_r <= p1_col_r;
      b_row_r <= p1_row_r;
    end
  end

  // stage 2: hand out one result per cycle while the skid entry is empty
  assign b_valid  = (b_mask_r != '0);
  assign b_single = ((b_mask_r & (b_mask_r - NUM_SLOTS'(1))) == '0);
  assign b_emit   = b_valid && !os_valid_r;
  assign b_take   = !b_valid || (b_single && !os_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_mask_r <= '0;
    end else if (p1_adv) begin
      b_mask_r <= mask_nxt;
    end else if (b_emit) begin
      b_mask_r <= b_mask_r & (b_mask_r - NUM_SLOTS'(1));
    end
  end

  always_comb begin
    if (b_mask_r[SLOT_UP_LEFT]) begin
      sel_slot = SLOT_UP_LEFT;
    end else if (b_mask_r[SLOT_UP]) begin
      sel_slot = SLOT_UP;
    end else if (b_mask_r[SLOT_LEFT]) begin
      sel_slot = SLOT_LEFT;
    end else begin
      sel_slot = SLOT_HERE;
    end

    unique case (sel_slot) inside
      SLOT_UP_LEFT, SLOT_UP: sel_row = b_row_r - ROW_W'(1);
      default:               sel_row = b_row_r;
    endcase
    unique case (sel_slot) inside
      SLOT_UP_LEFT, SLOT_LEFT: sel_col = b_col_r - COL_W'(1);
      default:                 sel_col = b_col_r;
    endcase

    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = PROD_W'(b_sum_r[sel_slot][ch]) * PROD_W'(recip(b_div_r[sel_slot]));
      quot[ch] = prod[ch][RECIP_SHIFT +: CH_W];
    end

    res_nxt.frame_done = (sel_slot == SLOT_HERE);
    res_nxt.run_last   = b_single;
    res_nxt.data       = {2'b00, COORD_W'(sel_col), COORD_W'(sel_row),
                          quot[2], quot[1], quot[0]};
  end

  // output register and skid entry
  assign out_pop = oh_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oh_valid_r <= 1'b0;
      os_valid_r <= 1'b0;
    end else if (os_valid_r) begin
      if (out_pop) begin
        os_valid_r <= 1'b0;
      end
    end else if (b_emit) begin
      if (!oh_valid_r || out_pop) begin
        oh_valid_r <= 1'b1;
      end else begin
        os_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      oh_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (os_valid_r) begin
      if (out_pop) begin
        oh_item_r <= os_item_r;
      end
    end else if (b_emit) begin
      if (!oh_valid_r || out_pop) begin
        oh_item_r <= res_nxt;
      end else begin
        os_item_r <= res_nxt;
      end
    end
  end

  assign out_tvalid   = oh_valid_r;
  assign out_tdata    = oh_item_r.data;
  assign out_tuser[0] = oh_item_r.frame_done;
  assign out_tlast    = oh_item_r.run_last;

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    os_valid_r |-> oh_valid_r)
    else $error("skid entry holds an item while the head is empty");

  a_accept_loads_p1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> p1_valid_r)
    else $error("accepted item did not reach the memory read stage");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("frame end is not the last result of its item");

  a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (col_r <= wid_last_r) && (row_r <= hgt_last_r))
    else $error("raster position outside the frame");

endmodule

>>> tb/box_blur_three_by_three_tb.sv
// Self-checking testbench for box_blur_three_by_three: streams RGB frames of many sizes
// against an in-file window-average predictor and checks every result in order.
// Depends on bbl_pkg and the box_blur_three_by_three RTL.
`timescale 1ns / 100ps

module box_blur_three_by_three_tb;
  import bbl_pkg::*;

  localparam int unsigned LIMIT      = 1_000_000;
  localparam int unsigned HOLD_LEN   = 200;
  localparam int unsigned SETTLE_GAP = 10;
  localparam int unsigned RAND_ITEMS = 110;
  localparam int unsigned MAX_SHOWN  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0]    blue;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    red;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               done;
    logic               last;
  } blur_px_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;   // blue, green, red
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // blue, green, red, row, col, pad
  logic [0:0]            out_tuser;       // frame_done
  logic                  out_tlast;       // run_last
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_blur_three_by_three u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [CFG_DATA_W-1:0] frame_w_reg;
  logic [CFG_DATA_W-1:0] frame_h_reg;
  logic [PIX_W-1:0]      older_line [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      prev_line  [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      cur_line   [MAX_WIDTH_DEF];
  int unsigned           col_pos;
  int unsigned           row_pos;
  blur_px_t              blur_expected [$];

  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count = 0;
  int unsigned           idle_pct = 34;
  int unsigned           holds_asked = 0;
  int unsigned           holds_served = 0;
  int unsigned           hold_left = 0;

  // stimulus-side view of the frame size
  logic [CFG_DATA_W-1:0] stim_w = CFG_DATA_W'(RESET_WIDTH);
  logic [CFG_DATA_W-1:0] stim_h = CFG_DATA_W'(RESET_HEIGHT);

  function automatic int unsigned dim_in_use(input logic [CFG_DATA_W-1:0] v,
                                             input int unsigned maxv);
    if (v < 3) return 3;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  function automatic blur_px_t window_average(input int unsigned row, input int unsigned col,
                                              input int unsigned r, input int unsigned w,
                                              input int unsigned h);
    int unsigned rlo, rhi, clo, chi, sb, sg, sr, cnt;
    logic [PIX_W-1:0] p;
    blur_px_t res;
    rlo = (row > 0) ? row - 1 : 0;
    rhi = (row + 1 < h) ? row + 1 : h - 1;
    clo = (col > 0) ? col - 1 : 0;
    chi = (col + 1 < w) ? col + 1 : w - 1;
    if (rhi > r) rhi = r;
    sb = 0;
    sg = 0;
    sr = 0;
    for (int unsigned k = rlo; k <= rhi; k++) begin
      for (int unsigned x = clo; x <= chi; x++) begin
        if (r == k) p = cur_line[x];
        else if (r - k == 1) p = prev_line[x];
        else p = older_line[x];
        sb += 32'(p[0 +: CH_W]);
        sg += 32'(p[CH_W +: CH_W]);
        sr += 32'(p[2*CH_W +: CH_W]);
      end
    end
    cnt = (rhi - rlo + 1) * (chi - clo + 1);
    res.blue  = CH_W'(sb / cnt);
    res.green = CH_W'(sg / cnt);
    res.red   = CH_W'(sr / cnt);
    res.row   = COORD_W'(row);
    res.col   = COORD_W'(col);
    res.done  = (row == h - 1) && (col == w - 1);
    res.last  = 1'b0;
    return res;
  endfunction

  task automatic blur_model_config(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_FRAME_WIDTH) begin
      frame_w_reg = val;
    end else if (idx == CFG_FRAME_HEIGHT) begin
      frame_h_reg = val;
    end else begin
      return;
    end
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic blur_model_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, r, c;
    bit row_end, last_row;
    blur_px_t burst [$];
    w = dim_in_use(frame_w_reg, MAX_WIDTH_DEF);
    h = dim_in_use(frame_h_reg, MAX_HEIGHT_DEF);
    r = row_pos;
    c = col_pos;
    row_end  = (c == w - 1);
    last_row = (r == h - 1);
    cur_line[c] = px;
    if (r >= 1 && c >= 1) begin
      burst.push_back(window_average(r - 1, c - 1, r, w, h));
      if (row_end) burst.push_back(window_average(r - 1, c, r, w, h));
    end
    if (last_row && c >= 1) begin
      burst.push_back(window_average(r, c - 1, r, w, h));
      if (row_end) burst.push_back(window_average(r, c, r, w, h));
    end
    if (burst.size() > 0) burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) blur_expected.push_back(burst[i]);
    if (row_end) begin
      older_line = prev_line;
      prev_line  = cur_line;
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  task automatic check_result();
    blur_px_t got, want;
    got.blue  = out_tdata[0 +: CH_W];
    got.green = out_tdata[CH_W +: CH_W];
    got.red   = out_tdata[2*CH_W +: CH_W];
    got.row   = out_tdata[PIX_W +: COORD_W];
    got.col   = out_tdata[PIX_W + COORD_W +: COORD_W];
    got.done  = out_tuser[0];
    got.last  = out_tlast;
    if (blur_expected.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_SHOWN)
        $display("unexpected result: row=%0d col=%0d b=%0d g=%0d r=%0d",
                 got.row, got.col, got.blue, got.green, got.red);
    end else begin
      want = blur_expected.pop_front();
      if (got.blue !== want.blue || got.green !== want.green || got.red !== want.red ||
          got.row !== want.row || got.col !== want.col || got.done !== want.done ||
          got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN) begin
          $display("mismatch exp: row=%0d col=%0d b=%0d g=%0d r=%0d done=%0b last=%0b",
                   want.row, want.col, want.blue, want.green, want.red, want.done, want.last);
          $display("         got: row=%0d col=%0d b=%0d g=%0d r=%0d done=%0b last=%0b",
                   got.row, got.col, got.blue, got.green, got.red, got.done, got.last);
        end
      end
    end
  endtask

  // predictor and checker, sampled on the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_w_reg = CFG_DATA_W'(RESET_WIDTH);
      frame_h_reg = CFG_DATA_W'(RESET_HEIGHT);
      col_pos = 0;
      row_pos = 0;
    end else begin
      if (cfg_valid && cfg_ready) blur_model_config(cfg_index, cfg_data);
      if (in_tvalid && in_tready) blur_model_pixel(in_tdata);
      if (out_tvalid && out_tready) check_result();
    end
  end

  // result sink: random stalls plus an occasional long hold
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_tready   <= 1'b0;
      hold_left    <= HOLD_LEN;
      holds_served <= holds_asked;
    end else begin
      out_tready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("box_blur_three_by_three_tb: errors");
      $finish;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] px);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic push_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) push_pixel(PIX_W'($urandom()));
  endtask

  // drain everything before touching the registers
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (blur_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) stim_w = val;
    if (idx == CFG_FRAME_HEIGHT) stim_h = val;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    settle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // reset size: a short run inside the first 640-pixel row releases nothing
  task automatic test_reset_size();
    push_random(RESET_WIDTH / 16);
  endtask

  task automatic test_min_frame();
    set_frame(3, 3);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h000000);
    push_pixel(24'hFF0080);
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_pixel(24'h00FF00);
    push_pixel(24'hFFFFFF);
    // undersized registers saturate to 3
    set_frame(0, 1);
    for (int i = 0; i < 9; i++) push_pixel(24'hFFFFFF);
  endtask

  // writes to unused indexes must not restart the frame
  task automatic test_ignored_index();
    set_frame(4, 3);
    push_random(6);
    settle();
    write_reg(CFG_SPARE_A, 12'hFFF);
    write_reg(CFG_SPARE_B, 12'h000);
    push_random(6);
  endtask

  // oversized width: the first row must not wrap early
  task automatic test_wide_frame();
    set_frame(12'hFFF, 3);
    push_random(24);
  endtask

  // oversized height, with neither side idling
  task automatic test_tall_frame();
    set_frame(3, 12'hFFF);
    idle_pct = 0;
    push_random(3 * 24);
    idle_pct = 34;
  endtask

  task automatic test_backpressure();
    set_frame(8, 6);
    holds_asked++;
    push_random(48);
  endtask

  task automatic test_random_frames();
    int unsigned sent, fsize, count;
    logic [CFG_DATA_W-1:0] wv, hv;
    bit need_cfg;
    sent = 0;
    need_cfg = 1'b1;
    while (sent < RAND_ITEMS) begin
      if (need_cfg || $urandom_range(99) < 70) begin
        settle();
        case ($urandom_range(9))
          0:       wv = CFG_DATA_W'($urandom_range(0, 2));
          1:       wv = CFG_DATA_W'($urandom_range(13, 40));
          default: wv = CFG_DATA_W'($urandom_range(3, 12));
        endcase
        case ($urandom_range(9))
          0:       hv = CFG_DATA_W'($urandom_range(0, 2));
          1:       hv = CFG_DATA_W'((wv > 12) ? $urandom_range(3, 4) : $urandom_range(9, 16));
          default: hv = CFG_DATA_W'($urandom_range(3, 8));
        endcase
        case ($urandom_range(3))
          0:       write_reg(CFG_FRAME_WIDTH, wv);
          1:       write_reg(CFG_FRAME_HEIGHT, hv);
          2: begin
            write_reg(CFG_FRAME_HEIGHT, hv);
            write_reg(CFG_FRAME_WIDTH, wv);
          end
          default: begin
            write_reg(CFG_FRAME_WIDTH, wv);
            write_reg(CFG_FRAME_HEIGHT, hv);
          end
        endcase
        need_cfg = 1'b0;
      end
      fsize = dim_in_use(stim_w, MAX_WIDTH_DEF) * dim_in_use(stim_h, MAX_HEIGHT_DEF);
      count = fsize;
      if ($urandom_range(99) < 15) begin
        count = $urandom_range(1, fsize - 1);
        need_cfg = 1'b1;
      end
      if (count > RAND_ITEMS - sent) count = RAND_ITEMS - sent;
      push_random(count);
      sent += count;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_min_frame();
    test_ignored_index();
    test_backpressure();
    test_wide_frame();
    test_tall_frame();
    test_random_frames();
    settle();
    if (mismatch_count == 0 && blur_expected.size() == 0) begin
      $display("box_blur_three_by_three_tb: clean");
    end else begin
      $display("box_blur_three_by_three_tb: errors");
    end
    $finish;
  end

endmodule
